/* rtl/hkm_pkg.sv */
// shared types and constants for the heartbeat keepalive monitor
package hkm_pkg;

    localparam int TIME_W   = 48;
    localparam int MS_W     = 20;
    localparam int US_W     = 30;
    localparam int MISS_W   = 8;
    localparam int CFG_W    = 20;
    localparam int IDX_W    = 2;
    localparam int US_PER_MS = 1000;

    // floor(x / 1000) = (x * DIV_RECIP) >> DIV_SHIFT for x below 2^30
    localparam int PROD_W    = 61;
    localparam int DIV_SHIFT = 40;
    localparam logic [30:0] DIV_RECIP = 31'd1099511628;

    localparam logic              RST_ENABLE     = 1'b1;
    localparam logic [MS_W-1:0]   RST_INTERVAL   = 20'd10000;
    localparam logic [MS_W-1:0]   RST_TIMEOUT    = 20'd5000;
    localparam logic [MISS_W-1:0] RST_MAX_MISSED = 8'd3;
    localparam logic [MISS_W-1:0] MISS_SAT       = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_CHECK = 2'd0,
        FUNC_SENT  = 2'd1,
        FUNC_PONG  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE     = 2'd0,
        REG_INTERVAL   = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_MAX_MISSED = 2'd3
    } reg_idx_t;

    typedef struct packed {
        func_t             func;
        logic [TIME_W-1:0] now_us;
    } evt_t;

    typedef struct packed {
        logic              send_due;
        logic              timeout_fired;
        logic              link_dead;
        logic              pong_pending;
        logic [MISS_W-1:0] misses;
        logic [MS_W-1:0]   wait_ms;
    } res_t;

    typedef struct packed {
        logic              enable;
        logic [MS_W-1:0]   ivl_ms;
        logic [US_W-1:0]   ivl_us;
        logic [US_W-1:0]   tmo_us;
        logic [MISS_W-1:0] miss_limit;
    } cfg_t;

    // status after the state update, plus the elapsed time still to be turned into ms
    typedef struct packed {
        logic              due;
        logic              fired;
        logic              dead;
        logic              pending;
        logic [MISS_W-1:0] misses;
        logic              use_interval;
        logic [US_W-1:0]   span_us;
    } stat_t;

endpackage

/* rtl/hkm_cfg.sv */
// configuration registers with precomputed microsecond limits
module hkm_cfg
    import hkm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data,
    output cfg_t             cfg
);

    cfg_t            cfg_reg;
    cfg_t            cfg_next;
    logic [US_W-1:0] data_us;

    assign data_us = US_W'({{(US_W-CFG_W){1'b0}}, wr_data} * US_W'(US_PER_MS));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_ENABLE:
                begin
                    cfg_next.enable = wr_data[0];
                end
                REG_INTERVAL:
                begin
                    cfg_next.ivl_ms = wr_data[MS_W-1:0];
                    cfg_next.ivl_us = data_us;
                end
                REG_TIMEOUT:
                begin
                    cfg_next.tmo_us = data_us;
                end
                REG_MAX_MISSED:
                begin
                    cfg_next.miss_limit = wr_data[MISS_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= RST_ENABLE;
            cfg_reg.ivl_ms     <= RST_INTERVAL;
            cfg_reg.ivl_us     <= US_W'(RST_INTERVAL * US_PER_MS);
            cfg_reg.tmo_us     <= US_W'(RST_TIMEOUT * US_PER_MS);
            cfg_reg.miss_limit <= RST_MAX_MISSED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/hkm_state.sv */
// request register, link state update and status register
module hkm_state
    import hkm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load_req,
    input  logic  fire,
    input  logic  load_stat,
    input  evt_t  evt,
    input  cfg_t  cfg,
    output stat_t stat
);

    evt_t              req_reg;
    stat_t             stat_reg;
    stat_t             stat_next;

    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic              pending_reg;
    logic              pending_next;
    logic              dead_reg;
    logic              dead_next;
    logic [MISS_W-1:0] miss_reg;
    logic [MISS_W-1:0] miss_next;

    logic [TIME_W-1:0] el_old;
    logic [TIME_W-1:0] el_new;
    logic [TIME_W-1:0] interval_w;
    logic              tmo_hit;
    logic              ge_old;
    logic              ge_now;
    logic              ge_new;
    logic [MISS_W-1:0] miss_inc;
    logic              fired;

    assign interval_w = TIME_W'(cfg.ivl_us);
    assign el_old     = req_reg.now_us - last_reg;
    assign tmo_hit    = el_old >= TIME_W'(cfg.tmo_us);
    assign ge_old     = el_old >= interval_w;
    assign ge_now     = req_reg.now_us >= interval_w;
    assign miss_inc   = (miss_reg == MISS_SAT) ? miss_reg : miss_reg + MISS_W'(1);

    always_comb
    begin
        last_next    = last_reg;
        pending_next = pending_reg;
        dead_next    = dead_reg;
        miss_next    = miss_reg;
        fired        = 1'b0;
        el_new       = el_old;
        ge_new       = ge_old;
        if (req_reg.func == FUNC_CLEAR)
        begin
            last_next    = '0;
            pending_next = 1'b0;
            dead_next    = 1'b0;
            miss_next    = '0;
            el_new       = req_reg.now_us;
            ge_new       = ge_now;
        end
        else if (cfg.enable)
        begin
            unique case (req_reg.func)
                FUNC_SENT:
                begin
                    last_next    = req_reg.now_us;
                    pending_next = 1'b1;
                    el_new       = '0;
                    ge_new       = (cfg.ivl_us == '0);
                end
                FUNC_PONG:
                begin
                    pending_next = 1'b0;
                    dead_next    = 1'b0;
                    miss_next    = '0;
                end
                FUNC_CHECK:
                begin
                    if (!dead_reg && pending_reg && tmo_hit)
                    begin
                        pending_next = 1'b0;
                        miss_next    = miss_inc;
                        if (miss_inc >= cfg.miss_limit)
                        begin
                            dead_next = 1'b1;
                            fired     = 1'b1;
                        end
                    end
                end
                default:
                begin
                    pending_next = pending_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        stat_next.use_interval = !cfg.enable || dead_next || pending_next;
        stat_next.due          = !stat_next.use_interval && ge_new;
        stat_next.fired        = fired;
        stat_next.dead         = dead_next;
        stat_next.pending      = pending_next;
        stat_next.misses       = miss_next;
        stat_next.span_us      = el_new[US_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '0;
            pending_reg <= 1'b0;
            dead_reg    <= 1'b0;
            miss_reg    <= '0;
        end
        else if (fire)
        begin
            last_reg    <= last_next;
            pending_reg <= pending_next;
            dead_reg    <= dead_next;
            miss_reg    <= miss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_req)
        begin
            req_reg <= evt;
        end
        if (load_stat)
        begin
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

    a_dead_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dead_reg) |-> (miss_reg != '0))
        else $error("timeout declared with zero miss count");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg.func == FUNC_CLEAR) |=>
        (last_reg == '0 && !pending_reg && !dead_reg && miss_reg == '0))
        else $error("clear request left state behind");

    a_send_stamps: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pending_reg) |-> (last_reg == $past(req_reg.now_us)))
        else $error("pong pending without send time");

endmodule

/* rtl/hkm_wait.sv */
// remaining interval in milliseconds by reciprocal multiply
module hkm_wait
    import hkm_pkg::*;
(
    input  logic  clk,
    input  logic  load_diff,
    input  cfg_t  cfg,
    input  stat_t stat,
    output res_t  res_next
);

    stat_t             diff_reg;
    stat_t             diff_next;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        diff_next         = stat;
        diff_next.span_us = cfg.ivl_us - stat.span_us;
    end

    always_ff @(posedge clk)
    begin
        if (load_diff)
        begin
            diff_reg <= diff_next;
        end
    end

    assign prod = PROD_W'(diff_reg.span_us) * PROD_W'(DIV_RECIP);

    always_comb
    begin
        res_next.send_due      = diff_reg.due;
        res_next.timeout_fired = diff_reg.fired;
        res_next.link_dead     = diff_reg.dead;
        res_next.pong_pending  = diff_reg.pending;
        res_next.misses        = diff_reg.misses;
        priority if (diff_reg.use_interval)
        begin
            res_next.wait_ms = cfg.ivl_ms;
        end
        else if (diff_reg.due)
        begin
            res_next.wait_ms = '0;
        end
        else
        begin
            res_next.wait_ms = prod[DIV_SHIFT+MS_W-1:DIV_SHIFT];
        end
    end

endmodule

/* rtl/heartbeat_keepalive_monitor.sv */
// top level of the heartbeat keepalive monitor
// state update, ms conversion and result are separate stages, fed from the request register
// throughput: one request per cycle while no stall holds the pipeline back
// the ready chain is combinational, so stall backs up only through full stages
// reset: config returns to its defaults, link state and all valid flags clear
module heartbeat_keepalive_monitor
    import hkm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    output logic             evt_stall,
    input  evt_t             evt,
    output logic             res_valid,
    input  logic             res_stall,
    output res_t             res,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data
);

    cfg_t  cfg;
    stat_t stat;
    res_t  res_next;
    res_t  res_reg;

    logic  req_v_reg;
    logic  stat_v_reg;
    logic  diff_v_reg;
    logic  res_valid_reg;
    logic  rdy_res;
    logic  rdy_diff;
    logic  rdy_stat;
    logic  rdy_req;
    logic  fire;

    assign rdy_res  = !res_valid_reg || !res_stall;
    assign rdy_diff = !diff_v_reg || rdy_res;
    assign rdy_stat = !stat_v_reg || rdy_diff;
    assign rdy_req  = !req_v_reg || rdy_stat;
    assign fire     = req_v_reg && rdy_stat;

    hkm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    hkm_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_req  (rdy_req),
        .fire      (fire),
        .load_stat (rdy_stat),
        .evt       (evt),
        .cfg       (cfg),
        .stat      (stat)
    );

    hkm_wait u_wait (
        .clk       (clk),
        .load_diff (rdy_diff),
        .cfg       (cfg),
        .stat      (stat),
        .res_next  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg     <= 1'b0;
            stat_v_reg    <= 1'b0;
            diff_v_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_req)
            begin
                req_v_reg <= evt_valid;
            end
            if (rdy_stat)
            begin
                stat_v_reg <= req_v_reg;
            end
            if (rdy_diff)
            begin
                diff_v_reg <= stat_v_reg;
            end
            if (rdy_res)
            begin
                res_valid_reg <= diff_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_res)
        begin
            res_reg <= res_next;
        end
    end

    assign evt_stall = !rdy_req;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_v_reg |-> !evt_stall)
        else $error("request stalled with empty input stage");

    a_fired_is_dead: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (!res_reg.timeout_fired || res_reg.link_dead))
        else $error("timeout fired without timed-out flag");

    a_due_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.send_due) |->
        (res_reg.wait_ms == '0 && !res_reg.pong_pending && !res_reg.link_dead))
        else $error("send due with inconsistent status");

endmodule

/* tb/sv/hkm_tb_pkg.sv */
`timescale 1ns / 1ps
// scoreboard with link status predictor for the heartbeat keepalive monitor testbench
package hkm_tb_pkg;
    import hkm_pkg::*;

    class keepalive_scoreboard;
        logic              enable;
        logic [MS_W-1:0]   ivl_ms;
        logic [MS_W-1:0]   tmo_ms;
        logic [MISS_W-1:0] miss_limit;
        logic [TIME_W-1:0] sent_at_us;
        logic              awaiting_pong;
        logic              dead_flag;
        logic [MISS_W-1:0] miss_count;
        res_t              expected_status_q[$];
        int unsigned       errors;

        function void init();
            enable        = RST_ENABLE;
            ivl_ms        = RST_INTERVAL;
            tmo_ms        = RST_TIMEOUT;
            miss_limit    = RST_MAX_MISSED;
            sent_at_us    = '0;
            awaiting_pong = 1'b0;
            dead_flag     = 1'b0;
            miss_count    = '0;
            errors        = 0;
            expected_status_q.delete();
        endfunction

        function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_ENABLE:     enable     = data[0];
                REG_INTERVAL:   ivl_ms     = data[MS_W-1:0];
                REG_TIMEOUT:    tmo_ms     = data[MS_W-1:0];
                REG_MAX_MISSED: miss_limit = data[MISS_W-1:0];
                default:        ;
            endcase
        endfunction

        function logic [63:0] since_send(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] diff;
            diff = now - sent_at_us;
            return {{(64-TIME_W){1'b0}}, diff};
        endfunction

        function res_t predict_status(evt_t e);
            res_t        r;
            logic [63:0] el;
            logic [63:0] iv_us;
            logic [63:0] to_us;
            logic [63:0] wait_full;
            r     = '0;
            to_us = {{(64-MS_W){1'b0}}, tmo_ms} * 64'd1000;
            iv_us = {{(64-MS_W){1'b0}}, ivl_ms} * 64'd1000;
            if (e.func == FUNC_CLEAR)
            begin
                sent_at_us    = '0;
                awaiting_pong = 1'b0;
                dead_flag     = 1'b0;
                miss_count    = '0;
            end
            else if (enable)
            begin
                if (e.func == FUNC_SENT)
                begin
                    sent_at_us    = e.now_us;
                    awaiting_pong = 1'b1;
                end
                else if (e.func == FUNC_PONG)
                begin
                    awaiting_pong = 1'b0;
                    miss_count    = '0;
                    dead_flag     = 1'b0;
                end
                else if (!dead_flag && awaiting_pong)
                begin
                    if (since_send(e.now_us) >= to_us)
                    begin
                        awaiting_pong = 1'b0;
                        if (miss_count != MISS_SAT)
                            miss_count = miss_count + 1'b1;
                        if (miss_count >= miss_limit)
                        begin
                            dead_flag       = 1'b1;
                            r.timeout_fired = 1'b1;
                        end
                    end
                end
            end
            el = since_send(e.now_us);
            if (!enable || dead_flag || awaiting_pong)
                r.wait_ms = ivl_ms;
            else if (el >= iv_us)
                r.send_due = 1'b1;
            else
            begin
                wait_full = (iv_us - el) / 64'd1000;
                r.wait_ms = wait_full[MS_W-1:0];
            end
            r.link_dead    = dead_flag;
            r.pong_pending = awaiting_pong;
            r.misses       = miss_count;
            return r;
        endfunction

        function void note_request(evt_t e);
            expected_status_q.push_back(predict_status(e));
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [MS_W-1:0] got, logic [MS_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(res_t got);
            res_t want;
            if (expected_status_q.size() == 0)
                report($sformatf("result %h with no request waiting", got));
            else
            begin
                want = expected_status_q.pop_front();
                check_field("send_due", MS_W'(got.send_due), MS_W'(want.send_due));
                check_field("timeout_fired", MS_W'(got.timeout_fired),
                            MS_W'(want.timeout_fired));
                check_field("link_dead", MS_W'(got.link_dead), MS_W'(want.link_dead));
                check_field("pong_pending", MS_W'(got.pong_pending),
                            MS_W'(want.pong_pending));
                check_field("misses", MS_W'(got.misses), MS_W'(want.misses));
                check_field("wait_ms", got.wait_ms, want.wait_ms);
            end
        endtask
    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// top level testbench for the heartbeat keepalive monitor
module tb_top;
    import hkm_pkg::*;
    import hkm_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             evt_valid;
    logic             evt_stall;
    evt_t             evt;
    logic             res_valid;
    logic             res_stall;
    res_t             res;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    keepalive_scoreboard link_sb;
    int unsigned         snd_idle;
    int unsigned         rcv_idle;
    logic                hold_req;
    int unsigned         cycle_cnt;
    logic [MS_W-1:0]     cfg_interval;
    logic [MS_W-1:0]     cfg_timeout;
    logic [TIME_W-1:0]   anchor_us;

    always #5 clk = ~clk;

    heartbeat_keepalive_monitor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    // receiver stall, with long hold-off when requested
    initial
    begin
        int unsigned hold_left;
        logic        hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        res_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 300;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            link_sb.check_result(res);
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    task automatic send_evt(evt_t e);
        while ($urandom_range(99) < snd_idle)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= e;
        do
            @(posedge clk);
        while (evt_stall);
        link_sb.note_request(e);
    endtask

    task automatic send_at(func_t f, logic [TIME_W-1:0] t);
        evt_t e;
        e.func   = f;
        e.now_us = t;
        send_evt(e);
    endtask

    task automatic put_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        link_sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_cfg(logic en, logic [MS_W-1:0] iv, logic [MS_W-1:0] to,
                             logic [MISS_W-1:0] mm);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        put_reg(REG_ENABLE, {junk[CFG_W-1:1], en});
        put_reg(REG_INTERVAL, iv);
        put_reg(REG_TIMEOUT, to);
        put_reg(REG_MAX_MISSED, {junk[CFG_W-1:MISS_W], mm});
        wr_en <= 1'b0;
        @(posedge clk);
        cfg_interval = iv;
        cfg_timeout  = to;
    endtask

    task automatic settle();
        while (link_sb.expected_status_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly times near the last send, offset around timeout and interval
    task automatic next_evt(output evt_t e);
        logic [63:0] to_us;
        logic [63:0] iv_us;
        logic [63:0] delta;
        int unsigned pick;
        to_us = {{(64-MS_W){1'b0}}, cfg_timeout} * 64'd1000;
        iv_us = {{(64-MS_W){1'b0}}, cfg_interval} * 64'd1000;
        pick  = $urandom_range(99);
        if (pick < 5)
        begin
            e.func   = func_t'($urandom_range(3));
            e.now_us = rand48();
        end
        else
        begin
            if ($urandom_range(39) == 0)
            begin
                if ($urandom_range(1) == 0)
                    anchor_us = rand48();
                else
                    anchor_us = {TIME_W{1'b1}} - TIME_W'($urandom_range(20000000));
            end
            if (pick < 50)
                e.func = FUNC_CHECK;
            else if (pick < 80)
                e.func = FUNC_SENT;
            else if (pick < 95)
                e.func = FUNC_PONG;
            else
                e.func = FUNC_CLEAR;
            case ($urandom_range(8))
                0:       delta = 64'd0;
                1:       delta = 64'($urandom_range(1000));
                2:       delta = to_us - 64'd1;
                3:       delta = to_us;
                4:       delta = to_us + 64'($urandom_range(2000));
                5:       delta = iv_us - 64'($urandom_range(1500));
                6:       delta = iv_us + 64'($urandom_range(1000));
                7:       delta = 64'($urandom_range(3 * cfg_timeout + 2)) * 64'd1000
                                 + 64'($urandom_range(999));
                default: delta = {32'd0, $urandom};
            endcase
            e.now_us = anchor_us + delta[TIME_W-1:0];
            if (e.func == FUNC_SENT)
                anchor_us = e.now_us;
        end
    endtask

    initial
    begin
        evt_t              e;
        int                p;
        int                n_items;
        logic              en;
        logic [MS_W-1:0]   iv;
        logic [MS_W-1:0]   to;
        logic [MISS_W-1:0] mm;

        rst_n        = 1'b0;
        evt_valid    = 1'b0;
        evt          = '0;
        wr_en        = 1'b0;
        wr_index     = REG_ENABLE;
        wr_data      = '0;
        hold_req     = 1'b0;
        snd_idle     = 18;
        rcv_idle     = 88;
        cfg_interval = RST_INTERVAL;
        cfg_timeout  = RST_TIMEOUT;
        anchor_us    = '0;
        link_sb      = new();
        link_sb.init();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: boundaries, misses up to timeout, wrap of the time base
        send_at(FUNC_CHECK, 48'd0);
        send_at(FUNC_CHECK, 48'hFFFF_FFFF_FFFF);
        send_at(FUNC_CHECK, 48'd10_000_000);
        send_at(FUNC_CHECK, 48'd9_999_999);
        send_at(FUNC_SENT, 48'd1000);
        send_at(FUNC_CHECK, 48'd5_000_999);
        send_at(FUNC_CHECK, 48'd5_001_000);
        send_at(FUNC_SENT, 48'd6_000_000);
        send_at(FUNC_CHECK, 48'd11_000_000);
        send_at(FUNC_SENT, 48'd20_000_000);
        send_at(FUNC_CHECK, 48'd25_000_000);
        send_at(FUNC_CHECK, 48'd40_000_000);
        send_at(FUNC_SENT, 48'd41_000_000);
        send_at(FUNC_PONG, 48'd41_000_001);
        send_at(FUNC_CLEAR, 48'hFFFF_FFFF_FFFF);
        send_at(FUNC_SENT, 48'hFFFF_FFFF_FF00);
        send_at(FUNC_CHECK, 48'd4_999_743);
        send_at(FUNC_CHECK, 48'd4_999_744);
        send_at(FUNC_CHECK, 48'h8000_0000_0000);
        send_at(FUNC_PONG, 48'h5555_5555_5555);
        send_at(FUNC_SENT, 48'hAAAA_AAAA_AAAA);
        send_at(FUNC_PONG, 48'hAAAA_AAAA_AAAA);
        send_at(FUNC_CLEAR, 48'd0);
        evt_valid <= 1'b0;
        settle();

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    en = 1'b1; iv = 20'd8; to = 20'd3; mm = 8'd2; n_items = 300;
                end
                1:
                begin
                    en = 1'b0; iv = 20'd8; to = 20'd3; mm = 8'd2; n_items = 100;
                end
                2:
                begin
                    en = 1'b1; iv = '0; to = '0; mm = '0; n_items = 200;
                end
                3:
                begin
                    en = 1'b1; iv = '1; to = '1; mm = '1; n_items = 200;
                end
                4:
                begin
                    en = 1'b1; iv = 20'd20; to = 20'd5; mm = 8'd1; n_items = 300;
                end
                5, 6:
                begin
                    en      = 1'b1;
                    iv      = MS_W'($urandom_range(40));
                    to      = MS_W'($urandom_range(25));
                    mm      = MISS_W'($urandom_range(6));
                    n_items = 330;
                end
                default:
                begin
                    en      = 1'b1;
                    iv      = MS_W'($urandom_range(1048575));
                    to      = MS_W'($urandom_range(1048575));
                    mm      = MISS_W'($urandom_range(255));
                    n_items = 330;
                end
            endcase
            apply_cfg(en, iv, to, mm);
            if (p == 3)
            begin
                snd_idle = 88;
                rcv_idle = 18;
            end
            if (p == 6)
            begin
                snd_idle = 0;
                rcv_idle = 0;
                hold_req = 1'b1;
            end
            repeat (n_items)
            begin
                next_evt(e);
                send_evt(e);
            end
            evt_valid <= 1'b0;
            settle();
        end

        if (link_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
